>>> hw/rtl/sis_pkg.sv
`default_nettype none

package sis_pkg;

    // coordinate width used inside the datapath
    localparam int COORD_BITS_DEF = 32;

    // outcome codes
    localparam logic [1:0] OUTCOME_NONE  = 2'd0;
    localparam logic [1:0] OUTCOME_TOUCH = 2'd1;
    localparam logic [1:0] OUTCOME_CROSS = 2'd2;

    typedef struct packed {
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] d_x;
        logic signed [31:0] d_y;
    } seg_item_t;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [31:0] cross_x;
        logic signed [31:0] cross_y;
    } res_item_t;

endpackage

`default_nettype wire

>>> hw/rtl/segment_intersection_top.sv
// Throughput: one item per cycle; every stage holds when a finished result is stalled.
// The depth is set by the restoring divider, one quotient bit per stage for x and y.
// Reset (rst_n, asynchronous, active low) clears all valid bits and sets the
// tolerance register to zero; no clearing pass is needed.
`default_nettype none

module segment_intersection_top
    import sis_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        seg_valid,
    output logic             seg_stall,
    input  wire seg_item_t   seg,
    output logic             res_valid,
    input  wire logic        res_stall,
    output res_item_t        res
);

    localparam int CW    = COORD_BITS;
    localparam int DF    = CW + 1;          // coordinate difference
    localparam int PR    = 2 * DF;          // product of differences
    localparam int SW    = PR + 1;          // cross / dot product
    localparam int DEN   = SW + 1;          // s2 - s1
    localparam int SPLIT = SW / 2 + 1;      // low slice of s for the numerator
    localparam int HI    = SW - SPLIT;
    localparam int LOP   = CW + SPLIT + 1;
    localparam int HIP   = CW + HI;
    localparam int TW    = CW + SW;         // c * s term
    localparam int NUM   = TW + 1;          // numerator
    localparam int NSTG  = CW + 10;

    typedef struct packed {
        logic [1:0]         outcome;
        logic signed [31:0] pt_x;
        logic signed [31:0] pt_y;
    } meta_t;

    logic [31:0]     tol_reg;
    logic [NSTG-1:0] vld_reg;
    logic            en;

    // pipeline advances unless the finished item is held
    assign en        = !(vld_reg[NSTG-1] && res_stall);
    assign seg_stall = vld_reg[NSTG-1] && res_stall;
    assign res_valid = vld_reg[NSTG-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= '0;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                tol_reg <= cfg_wr_data;
            end
            if (en)
            begin
                vld_reg <= {vld_reg[NSTG-2:0], seg_valid};
            end
        end
    end

    // stage 1: narrow coordinates
    logic signed [CW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg, dx_reg, dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg <= seg.a_x[CW-1:0];
            ay_reg <= seg.a_y[CW-1:0];
            bx_reg <= seg.b_x[CW-1:0];
            by_reg <= seg.b_y[CW-1:0];
            cx_reg <= seg.c_x[CW-1:0];
            cy_reg <= seg.c_y[CW-1:0];
            dx_reg <= seg.d_x[CW-1:0];
            dy_reg <= seg.d_y[CW-1:0];
        end
    end

    // stage 2: differences
    logic signed [DF-1:0] df_reg [0:19];
    logic signed [DF-1:0] df_next [0:19];
    logic signed [CW-1:0] p2_ax_reg, p2_ay_reg, p2_bx_reg, p2_by_reg;
    logic signed [CW-1:0] p2_cx_reg, p2_cy_reg, p2_dx_reg, p2_dy_reg;

    always_comb
    begin
        df_next[0]  = DF'(bx_reg) - DF'(ax_reg);
        df_next[1]  = DF'(by_reg) - DF'(ay_reg);
        df_next[2]  = DF'(cx_reg) - DF'(ax_reg);
        df_next[3]  = DF'(cy_reg) - DF'(ay_reg);
        df_next[4]  = DF'(dx_reg) - DF'(ax_reg);
        df_next[5]  = DF'(dy_reg) - DF'(ay_reg);
        df_next[6]  = DF'(dx_reg) - DF'(cx_reg);
        df_next[7]  = DF'(dy_reg) - DF'(cy_reg);
        df_next[8]  = DF'(ax_reg) - DF'(cx_reg);
        df_next[9]  = DF'(ay_reg) - DF'(cy_reg);
        df_next[10] = DF'(bx_reg) - DF'(cx_reg);
        df_next[11] = DF'(by_reg) - DF'(cy_reg);
        df_next[12] = DF'(ax_reg) - DF'(dx_reg);
        df_next[13] = DF'(ay_reg) - DF'(dy_reg);
        df_next[14] = DF'(bx_reg) - DF'(dx_reg);
        df_next[15] = DF'(by_reg) - DF'(dy_reg);
        df_next[16] = DF'(cx_reg) - DF'(bx_reg);
        df_next[17] = DF'(cy_reg) - DF'(by_reg);
        df_next[18] = DF'(dx_reg) - DF'(bx_reg);
        df_next[19] = DF'(dy_reg) - DF'(by_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            df_reg    <= df_next;
            p2_ax_reg <= ax_reg;
            p2_ay_reg <= ay_reg;
            p2_bx_reg <= bx_reg;
            p2_by_reg <= by_reg;
            p2_cx_reg <= cx_reg;
            p2_cy_reg <= cy_reg;
            p2_dx_reg <= dx_reg;
            p2_dy_reg <= dy_reg;
        end
    end

    // stage 3: sixteen products, one per lane
    logic signed [PR-1:0] pr_reg [0:15];
    logic signed [PR-1:0] pr_next [0:15];
    logic signed [CW-1:0] p3_ax_reg, p3_ay_reg, p3_bx_reg, p3_by_reg;
    logic signed [CW-1:0] p3_cx_reg, p3_cy_reg, p3_dx_reg, p3_dy_reg;

    always_comb
    begin
        // cross products s1..s4, two terms each
        pr_next[0]  = df_reg[0]  * df_reg[3];
        pr_next[1]  = df_reg[2]  * df_reg[1];
        pr_next[2]  = df_reg[0]  * df_reg[5];
        pr_next[3]  = df_reg[4]  * df_reg[1];
        pr_next[4]  = df_reg[6]  * df_reg[9];
        pr_next[5]  = df_reg[8]  * df_reg[7];
        pr_next[6]  = df_reg[6]  * df_reg[11];
        pr_next[7]  = df_reg[10] * df_reg[7];
        // dot products for endpoints C, D, A, B
        pr_next[8]  = df_reg[8]  * df_reg[10];
        pr_next[9]  = df_reg[9]  * df_reg[11];
        pr_next[10] = df_reg[12] * df_reg[14];
        pr_next[11] = df_reg[13] * df_reg[15];
        pr_next[12] = df_reg[2]  * df_reg[4];
        pr_next[13] = df_reg[3]  * df_reg[5];
        pr_next[14] = df_reg[16] * df_reg[18];
        pr_next[15] = df_reg[17] * df_reg[19];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pr_reg    <= pr_next;
            p3_ax_reg <= p2_ax_reg;
            p3_ay_reg <= p2_ay_reg;
            p3_bx_reg <= p2_bx_reg;
            p3_by_reg <= p2_by_reg;
            p3_cx_reg <= p2_cx_reg;
            p3_cy_reg <= p2_cy_reg;
            p3_dx_reg <= p2_dx_reg;
            p3_dy_reg <= p2_dy_reg;
        end
    end

    // stage 4: cross and dot sums
    logic signed [SW-1:0] s_reg [0:3];
    logic signed [SW-1:0] dot_reg [0:3];
    logic signed [CW-1:0] p4_ax_reg, p4_ay_reg, p4_bx_reg, p4_by_reg;
    logic signed [CW-1:0] p4_cx_reg, p4_cy_reg, p4_dx_reg, p4_dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                s_reg[k]   <= SW'(pr_reg[2*k]) - SW'(pr_reg[2*k+1]);
                dot_reg[k] <= SW'(pr_reg[2*k+8]) + SW'(pr_reg[2*k+9]);
            end
            p4_ax_reg <= p3_ax_reg;
            p4_ay_reg <= p3_ay_reg;
            p4_bx_reg <= p3_bx_reg;
            p4_by_reg <= p3_by_reg;
            p4_cx_reg <= p3_cx_reg;
            p4_cy_reg <= p3_cy_reg;
            p4_dx_reg <= p3_dx_reg;
            p4_dy_reg <= p3_dy_reg;
        end
    end

    // stage 5: signs with tolerance band, outcome, denominator
    logic signed [SW:0] tol_pos, tol_neg;
    logic [3:0] pos, neg, zer;
    logic [3:0] dot_ok;
    logic       proper;
    meta_t      meta5_next;

    assign tol_pos = (SW+1)'({1'b0, tol_reg});
    assign tol_neg = -tol_pos;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            pos[k]    = (SW+1)'(s_reg[k]) > tol_pos;
            neg[k]    = (SW+1)'(s_reg[k]) < tol_neg;
            zer[k]    = !pos[k] && !neg[k];
            dot_ok[k] = (SW+1)'(dot_reg[k]) <= tol_pos;
        end
        proper = ((pos[0] && neg[1]) || (neg[0] && pos[1]))
              && ((pos[2] && neg[3]) || (neg[2] && pos[3]));
        meta5_next = '{OUTCOME_NONE, 32'sd0, 32'sd0};
        priority if (proper)
        begin
            meta5_next.outcome = OUTCOME_CROSS;
        end
        else if (zer[0] && dot_ok[0])
        begin
            meta5_next = '{OUTCOME_TOUCH, 32'(p4_cx_reg), 32'(p4_cy_reg)};
        end
        else if (zer[1] && dot_ok[1])
        begin
            meta5_next = '{OUTCOME_TOUCH, 32'(p4_dx_reg), 32'(p4_dy_reg)};
        end
        else if (zer[2] && dot_ok[2])
        begin
            meta5_next = '{OUTCOME_TOUCH, 32'(p4_ax_reg), 32'(p4_ay_reg)};
        end
        else if (zer[3] && dot_ok[3])
        begin
            meta5_next = '{OUTCOME_TOUCH, 32'(p4_bx_reg), 32'(p4_by_reg)};
        end
        else
        begin
            meta5_next = '{OUTCOME_NONE, 32'sd0, 32'sd0};
        end
    end

    meta_t                 m5_reg, m6_reg, m7_reg, m8_reg;
    logic signed [DEN-1:0] den5_reg, den6_reg, den7_reg, den8_reg;
    logic signed [SW-1:0]  s1_5_reg, s2_5_reg;
    logic signed [CW-1:0]  p5_cx_reg, p5_cy_reg, p5_dx_reg, p5_dy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m5_reg    <= meta5_next;
            den5_reg  <= DEN'(s_reg[1]) - DEN'(s_reg[0]);
            s1_5_reg  <= s_reg[0];
            s2_5_reg  <= s_reg[1];
            p5_cx_reg <= p4_cx_reg;
            p5_cy_reg <= p4_cy_reg;
            p5_dx_reg <= p4_dx_reg;
            p5_dy_reg <= p4_dy_reg;
        end
    end

    // stage 6: numerator partial products, s split into high and low slices
    logic signed [SPLIT:0]  s1_lo, s2_lo;
    logic signed [HI-1:0]   s1_hi, s2_hi;
    logic signed [LOP-1:0]  cxl_reg, cyl_reg, dxl_reg, dyl_reg;
    logic signed [HIP-1:0]  cxh_reg, cyh_reg, dxh_reg, dyh_reg;

    assign s1_lo = $signed({1'b0, s1_5_reg[SPLIT-1:0]});
    assign s2_lo = $signed({1'b0, s2_5_reg[SPLIT-1:0]});
    assign s1_hi = s1_5_reg[SW-1:SPLIT];
    assign s2_hi = s2_5_reg[SW-1:SPLIT];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cxl_reg  <= p5_cx_reg * s2_lo;
            cyl_reg  <= p5_cy_reg * s2_lo;
            dxl_reg  <= p5_dx_reg * s1_lo;
            dyl_reg  <= p5_dy_reg * s1_lo;
            cxh_reg  <= p5_cx_reg * s2_hi;
            cyh_reg  <= p5_cy_reg * s2_hi;
            dxh_reg  <= p5_dx_reg * s1_hi;
            dyh_reg  <= p5_dy_reg * s1_hi;
            m6_reg   <= m5_reg;
            den6_reg <= den5_reg;
        end
    end

    // stage 7: recombine the slices into c*s2 and d*s1
    logic signed [TW-1:0] tcx_reg, tcy_reg, tdx_reg, tdy_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tcx_reg  <= (TW'(cxh_reg) <<< SPLIT) + TW'(cxl_reg);
            tcy_reg  <= (TW'(cyh_reg) <<< SPLIT) + TW'(cyl_reg);
            tdx_reg  <= (TW'(dxh_reg) <<< SPLIT) + TW'(dxl_reg);
            tdy_reg  <= (TW'(dyh_reg) <<< SPLIT) + TW'(dyl_reg);
            m7_reg   <= m6_reg;
            den7_reg <= den6_reg;
        end
    end

    // stage 8: numerators
    logic signed [NUM-1:0] nx_reg, ny_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nx_reg   <= NUM'(tcx_reg) - NUM'(tdx_reg);
            ny_reg   <= NUM'(tcy_reg) - NUM'(tdy_reg);
            m8_reg   <= m7_reg;
            den8_reg <= den7_reg;
        end
    end

    // stage 9 onward: magnitudes, then one quotient bit per stage
    logic [NUM-1:0] rx_reg [0:CW];
    logic [NUM-1:0] ry_reg [0:CW];
    logic [CW-1:0]  qx_reg [0:CW];
    logic [CW-1:0]  qy_reg [0:CW];
    logic [DEN-1:0] ud_reg [0:CW];
    logic           negx_reg [0:CW];
    logic           negy_reg [0:CW];
    meta_t          md_reg [0:CW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rx_reg[0]   <= nx_reg[NUM-1] ? NUM'(-nx_reg) : NUM'(nx_reg);
            ry_reg[0]   <= ny_reg[NUM-1] ? NUM'(-ny_reg) : NUM'(ny_reg);
            ud_reg[0]   <= den8_reg[DEN-1] ? DEN'(-den8_reg) : DEN'(den8_reg);
            qx_reg[0]   <= '0;
            qy_reg[0]   <= '0;
            negx_reg[0] <= nx_reg[NUM-1] ^ den8_reg[DEN-1];
            negy_reg[0] <= ny_reg[NUM-1] ^ den8_reg[DEN-1];
            md_reg[0]   <= m8_reg;
        end
    end

    for (genvar i = 0; i < CW; i++)
    begin : g_div
        localparam int BP = CW - 1 - i;
        logic [NUM-1:0] trial;
        logic           gex, gey;

        assign trial = NUM'(ud_reg[i]) << BP;
        assign gex   = rx_reg[i] >= trial;
        assign gey   = ry_reg[i] >= trial;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rx_reg[i+1]   <= gex ? rx_reg[i] - trial : rx_reg[i];
                ry_reg[i+1]   <= gey ? ry_reg[i] - trial : ry_reg[i];
                // bit BP is still clear on entry to this stage
                qx_reg[i+1]   <= qx_reg[i] | (CW'(gex) << BP);
                qy_reg[i+1]   <= qy_reg[i] | (CW'(gey) << BP);
                ud_reg[i+1]   <= ud_reg[i];
                negx_reg[i+1] <= negx_reg[i];
                negy_reg[i+1] <= negy_reg[i];
                md_reg[i+1]   <= md_reg[i];
            end
        end
    end

    // output stage: sign of the quotient, choice of point
    logic signed [CW-1:0] qsx, qsy;
    res_item_t            res_next;
    res_item_t            res_reg;

    assign qsx = negx_reg[CW] ? -$signed(qx_reg[CW]) : $signed(qx_reg[CW]);
    assign qsy = negy_reg[CW] ? -$signed(qy_reg[CW]) : $signed(qy_reg[CW]);

    always_comb
    begin
        res_next.outcome = md_reg[CW].outcome;
        if (md_reg[CW].outcome == OUTCOME_CROSS)
        begin
            res_next.cross_x = 32'(qsx);
            res_next.cross_y = 32'(qsy);
        end
        else
        begin
            res_next.cross_x = md_reg[CW].pt_x;
            res_next.cross_y = md_reg[CW].pt_y;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

`ifndef NO_ASSERTIONS
    // a proper crossing always has a nonzero denominator
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[4] && m5_reg.outcome == OUTCOME_CROSS) |-> (den5_reg != '0))
        else $error("crossing with zero denominator");

    // no intersection reports the origin
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.outcome == OUTCOME_NONE) |-> (res.cross_x == 0 && res.cross_y == 0))
        else $error("no-intersection result carries a point");

    // outcome code never out of range at the output
    a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (res.outcome == OUTCOME_NONE || res.outcome == OUTCOME_TOUCH
                       || res.outcome == OUTCOME_CROSS))
        else $error("bad outcome code");

    // a held result keeps the whole pipe frozen
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> $stable(vld_reg))
        else $error("pipeline moved while output stalled");
`endif

endmodule

`default_nettype wire

>>> bench/segment_intersection_top_tb.sv
`timescale 1ns / 1ps

module segment_intersection_top_tb;
    import sis_pkg::*;

    localparam int LATENCY = 42;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1050;

    // exact-width helpers for the predictor
    typedef logic signed [127:0] wide_t;

    // holds the expected results of accepted items, oldest first
    class intersect_scoreboard;
        res_item_t pending[$];
        logic [31:0] tolerance;
        int errors;

        function new();
            tolerance = '0;
            errors = 0;
        endfunction

        // sign with a tolerance band
        function int band_sign(wide_t s);
            wide_t t;
            t = wide_t'({96'd0, tolerance});
            if (s > t) return 1;
            if (s < -t) return -1;
            return 0;
        endfunction

        function wide_t cross3(wide_t ax, wide_t ay, wide_t bx, wide_t by,
                               wide_t cx, wide_t cy);
            return (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
        endfunction

        // (p1 - e).(p2 - e) at most the tolerance
        function bit lies_within(wide_t ex, wide_t ey, wide_t p1x, wide_t p1y,
                                 wide_t p2x, wide_t p2y);
            wide_t dp;
            dp = (p1x - ex) * (p2x - ex) + (p1y - ey) * (p2y - ey);
            return dp <= wide_t'({96'd0, tolerance});
        endfunction

        // division truncating toward zero, zero on a zero denominator
        function wide_t trunc_div(wide_t n, wide_t d);
            if (d == 0) return 0;
            return n / d;
        endfunction

        function void note_segments(seg_item_t s);
            wide_t ax, ay, bx, by, cx, cy, dx, dy, s1, s2, den;
            int d1, d2, d3, d4;
            res_item_t r;
            ax = s.a_x; ay = s.a_y; bx = s.b_x; by = s.b_y;
            cx = s.c_x; cy = s.c_y; dx = s.d_x; dy = s.d_y;
            s1 = cross3(ax, ay, bx, by, cx, cy);
            s2 = cross3(ax, ay, bx, by, dx, dy);
            d1 = band_sign(s1);
            d2 = band_sign(s2);
            d3 = band_sign(cross3(cx, cy, dx, dy, ax, ay));
            d4 = band_sign(cross3(cx, cy, dx, dy, bx, by));
            r.outcome = OUTCOME_TOUCH;
            if (d1 * d2 == -1 && d3 * d4 == -1) begin
                den = s2 - s1;
                r.cross_x = 32'(trunc_div(cx * s2 - dx * s1, den));
                r.cross_y = 32'(trunc_div(cy * s2 - dy * s1, den));
                r.outcome = OUTCOME_CROSS;
            end else if (d1 == 0 && lies_within(cx, cy, ax, ay, bx, by)) begin
                r.cross_x = s.c_x; r.cross_y = s.c_y;
            end else if (d2 == 0 && lies_within(dx, dy, ax, ay, bx, by)) begin
                r.cross_x = s.d_x; r.cross_y = s.d_y;
            end else if (d3 == 0 && lies_within(ax, ay, cx, cy, dx, dy)) begin
                r.cross_x = s.a_x; r.cross_y = s.a_y;
            end else if (d4 == 0 && lies_within(bx, by, cx, cy, dx, dy)) begin
                r.cross_x = s.b_x; r.cross_y = s.b_y;
            end else begin
                r.cross_x = '0; r.cross_y = '0;
                r.outcome = OUTCOME_NONE;
            end
            pending.push_back(r);
        endfunction

        function void check_result(res_item_t got);
            res_item_t want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.outcome !== want.outcome) begin
                $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                         got.outcome);
                errors++;
            end
            if (got.cross_x !== want.cross_x) begin
                $display("%0t: cross_x expected %0d actual %0d", $time, want.cross_x,
                         got.cross_x);
                errors++;
            end
            if (got.cross_y !== want.cross_y) begin
                $display("%0t: cross_y expected %0d actual %0d", $time, want.cross_y,
                         got.cross_y);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic seg_valid = 1'b0;
    logic seg_stall;
    seg_item_t seg = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_item_t res;

    intersect_scoreboard board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_off = 1'b0;
    int quiet_cycles = 0;

    always #4 clk = ~clk;

    segment_intersection_top dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .seg_valid(seg_valid), .seg_stall(seg_stall), .seg(seg),
        .res_valid(res_valid), .res_stall(res_stall), .res(res)
    );

    // sample both handshakes at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (seg_valid && !seg_stall) board.note_segments(seg);
            if (res_valid && !res_stall) board.check_result(res);
            if ((seg_valid && !seg_stall) || (res_valid && !res_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver stall pattern
    always @(negedge clk) begin
        res_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
    end

    // watchdog on lack of progress
    always @(posedge clk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // offer one item, hold it until taken; valid stays high until the next call idles or drain drops it
    task automatic send_segments(seg_item_t s);
        while ($urandom_range(99) < send_idle_pct) begin
            seg_valid <= 1'b0;
            @(negedge clk);
        end
        seg <= s;
        seg_valid <= 1'b1;
        @(posedge clk);
        while (seg_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        seg_valid <= 1'b0;
        while (board.pending.size() != 0) @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    task automatic write_tolerance(logic [31:0] v);
        cfg_wr_data <= v;
        cfg_wr_en <= 1'b1;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        board.tolerance = v;
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(40)) - 20);
            2: return $urandom_range(1) ? 32'h7fff_ffff - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
            default: return 32'($signed($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // mostly crossing and touching geometry, the rest noise
    function automatic seg_item_t rand_segments();
        seg_item_t s;
        int mode, kind;
        mode = $urandom_range(3);
        kind = $urandom_range(9);
        s.a_x = rand_coord(mode); s.a_y = rand_coord(mode);
        s.b_x = rand_coord(mode); s.b_y = rand_coord(mode);
        s.c_x = rand_coord(mode); s.c_y = rand_coord(mode);
        s.d_x = rand_coord(mode); s.d_y = rand_coord(mode);
        if (kind < 3) begin
            // crossing box: AB one diagonal, CD the other
            s.c_x = s.a_x; s.c_y = s.b_y; s.d_x = s.b_x; s.d_y = s.a_y;
        end else if (kind < 5) begin
            s.c_x = s.a_x; s.c_y = s.a_y;                 // shared endpoint
        end else if (kind == 5) begin
            s.d_x = s.b_x; s.d_y = s.b_y;
        end else if (kind == 6) begin
            // C at a midpoint of AB on an even grid
            s.a_x = s.a_x & ~32'h1; s.a_y = s.a_y & ~32'h1;
            s.b_x = s.b_x & ~32'h1; s.b_y = s.b_y & ~32'h1;
            s.c_x = (s.a_x >>> 1) + (s.b_x >>> 1);
            s.c_y = (s.a_y >>> 1) + (s.b_y >>> 1);
        end
        return s;
    endfunction

    function automatic seg_item_t make_seg(int ax, int ay, int bx, int by,
                                           int cx, int cy, int dx, int dy);
        seg_item_t s;
        s.a_x = ax; s.a_y = ay; s.b_x = bx; s.b_y = by;
        s.c_x = cx; s.c_y = cy; s.d_x = dx; s.d_y = dy;
        return s;
    endfunction

    initial begin
        seg_item_t s;
        int hold_len;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: crossing, touches at each endpoint, collinear, none, extremes
        send_segments(make_seg(0, 0, 10, 10, 0, 10, 10, 0));
        send_segments(make_seg(0, 0, 10, 0, 5, 0, 5, 7));
        send_segments(make_seg(0, 0, 10, 0, 5, 7, 5, 0));
        send_segments(make_seg(5, 0, 5, 7, 0, 0, 10, 0));
        send_segments(make_seg(5, 7, 5, 0, 0, 0, 10, 0));
        send_segments(make_seg(0, 0, 10, 0, 3, 0, 20, 0));
        send_segments(make_seg(0, 0, 10, 0, 11, 0, 20, 0));
        send_segments(make_seg(0, 0, 1, 1, 5, 5, 6, 9));
        send_segments(make_seg(0, 0, 0, 0, 0, 0, 0, 0));
        send_segments(make_seg(0, 0, 7, 3, 0, 3, 7, 0));
        send_segments(make_seg(-7, -3, 0, 0, -7, 0, 0, -3));
        send_segments(make_seg(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                               32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000));
        send_segments(make_seg(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                               32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff));
        send_segments(make_seg(-1, -1, -1, -1, -1, -1, 32'h8000_0000, 32'h7fff_ffff));
        drain();

        // tolerance band: near misses become touches
        write_tolerance(32'd5);
        send_segments(make_seg(0, 0, 10, 0, 5, 1, 5, 9));
        send_segments(make_seg(0, 0, 10, 0, 11, 0, 20, 0));
        send_segments(make_seg(0, 0, 10, 10, 0, 10, 10, 0));
        drain();
        write_tolerance(32'hffff_ffff);
        send_segments(make_seg(0, 0, 10, 10, 0, 10, 10, 0));
        send_segments(make_seg(0, 0, 100, 0, 50, 3, 50, 90));
        send_segments(make_seg(32'h8000_0000, 0, 32'h7fff_ffff, 0, 0, 1, 0, -1));
        drain();

        // random phases with different tolerances and idling patterns
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 12; recv_idle_pct = 66; end
                1: begin send_idle_pct = 66; recv_idle_pct = 12; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int t = 0; t < 4; t++) begin
                case (t)
                    0: write_tolerance(32'd0);
                    1: write_tolerance($urandom_range(3));
                    2: write_tolerance($urandom());
                    default: write_tolerance(32'hffff_ffff);
                endcase
                for (int i = 0; i < RANDOM_ITEMS / 12; i++) begin
                    s = rand_segments();
                    send_segments(s);
                end
                drain();
            end
        end

        // long receiver hold-off while the sender keeps offering
        write_tolerance(32'd0);
        hold_off = 1'b1;
        fork
            begin
                hold_len = 0;
                while (hold_len < 200) begin
                    @(negedge clk);
                    hold_len++;
                end
                hold_off = 1'b0;
            end
            begin
                for (int i = 0; i < 80; i++) send_segments(rand_segments());
            end
        join
        drain();

        if (board.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
